>>> src/swtq_pkg.sv
// Shared types, widths and status codes of the sorted wakeup timer queue.
package swtq_pkg;

    localparam int TIME_W      = 63;
    localparam int ID_W        = 8;
    localparam int ST_W        = 2;
    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int REL_W       = $clog2(MAX_RESULTS + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_WOKEN    = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] wake_time;
        logic [ID_W-1:0]   waiter_id;
    } t_entry;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   woken_id;
        logic [TIME_W-1:0] woken_time;
        logic              last;
    } t_result;

endpackage

>>> src/sorted_wakeup_timer_queue_top.sv
// Top level of the sorted wakeup timer queue: entry memory, sequencer and result register.
//
// The queue holds up to DEPTH waiters sorted by wake time in a ring inside one
// memory with a registered read. An insert transfer walks down from the
// newest entry, moving each later entry up one slot, one entry per cycle,
// and then gives its single result; a full queue answers without reading
// the memory, with a rejected status. A tick transfer reads from the head
// one entry per cycle while the output register is free and releases every
// entry whose wake time is at or before the given time, earliest first, up
// to sixteen per tick, with the final release marked last; a tick that
// releases nothing gives one none-expired result. The memory's single read
// port sets this one-entry-per-cycle pace. Equal wake times keep arrival
// order. The queue takes one input transfer at a time and holds off new
// ones until the previous one has placed its last result in the output
// register, which parts the input from a stalled consumer.
module sorted_wakeup_timer_queue_top #(
    parameter int DEPTH = swtq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [swtq_pkg::TIME_W-1:0] i_wake_time,
    input  logic [swtq_pkg::ID_W-1:0]   i_waiter_id,
    input  logic [swtq_pkg::TIME_W-1:0] i_now_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [swtq_pkg::ST_W-1:0]   o_status,
    output logic [swtq_pkg::ID_W-1:0]   o_woken_id,
    output logic [swtq_pkg::TIME_W-1:0] o_woken_time,
    output logic                        o_last
);
    import swtq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_rdata;

    logic            res_load;
    t_result         res;
    logic            out_free;

    // Result register: one entry that can be reloaded in the cycle it is taken.
    logic            r_o_valid;
    t_result         r_out;

    assign out_free = !r_o_valid || !i_stall;

    swtq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swtq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_wake_time (i_wake_time),
        .i_waiter_id (i_waiter_id),
        .i_now_time  (i_now_time),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_out.status;
    assign o_woken_id   = r_out.woken_id;
    assign o_woken_time = r_out.woken_time;
    assign o_last       = r_out.last;

endmodule

>>> src/swtq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/swtq_ctrl.sv
// Sequencer that keeps the entry memory sorted as a ring and walks it for inserts and ticks.
module swtq_ctrl #(
    parameter int DEPTH = swtq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [swtq_pkg::TIME_W-1:0] i_wake_time,
    input  logic [swtq_pkg::ID_W-1:0]   i_waiter_id,
    input  logic [swtq_pkg::TIME_W-1:0] i_now_time,
    input  logic                        i_out_free,
    output logic                        o_res_load,
    output swtq_pkg::t_result           o_res,
    output logic                        o_we,
    output logic [$clog2(DEPTH)-1:0]    o_waddr,
    output swtq_pkg::t_entry            o_wdata,
    output logic                        o_re,
    output logic [$clog2(DEPTH)-1:0]    o_raddr,
    input  swtq_pkg::t_entry            i_rdata
);
    import swtq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CMP  = 3'd1;
    localparam logic [2:0] S_INS_WR   = 3'd2;
    localparam logic [2:0] S_TICK_CMP = 3'd3;
    localparam logic [2:0] S_EMIT     = 3'd4;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    // Control state.
    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic            r_pend_v, n_pend_v;

    // Working registers.
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_wr, n_wr;
    logic [CW-1:0]     r_left, n_left;
    logic [REL_W-1:0]  r_rel, n_rel;
    t_entry            r_new, n_new;
    logic [TIME_W-1:0] r_now, n_now;
    t_result           r_pend, n_pend;

    logic expired;

    assign o_stall = (r_state != S_IDLE);
    assign expired = (i_rdata.wake_time <= r_now);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_tail   = r_tail;
        n_pend_v = r_pend_v;
        n_ptr    = r_ptr;
        n_wr     = r_wr;
        n_left   = r_left;
        n_rel    = r_rel;
        n_new    = r_new;
        n_now    = r_now;
        n_pend   = r_pend;

        o_we       = 1'b0;
        o_waddr    = r_wr;
        o_wdata    = r_new;
        o_re       = 1'b0;
        o_raddr    = r_ptr;
        o_res_load = 1'b0;
        o_res      = r_pend;
        o_res.last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pend = '{status: ST_INSERTED, woken_id: '0, woken_time: '0, last: 1'b1};
                    if (i_operation == OP_INSERT) begin
                        n_new = '{wake_time: i_wake_time, waiter_id: i_waiter_id};
                        if (r_count == CW'(DEPTH)) begin
                            n_pend.status = ST_FULL;
                            n_state       = S_EMIT;
                        end else if (r_count == '0) begin
                            o_we    = 1'b1;
                            o_waddr = r_tail;
                            o_wdata = '{wake_time: i_wake_time, waiter_id: i_waiter_id};
                            n_tail  = f_inc(r_tail);
                            n_count = r_count + 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = f_dec(r_tail);
                            n_ptr   = f_dec(r_tail);
                            n_wr    = r_tail;
                            n_left  = r_count;
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        n_now = i_now_time;
                        if (r_count == '0) begin
                            n_pend.status = ST_NONE;
                            n_state       = S_EMIT;
                        end else begin
                            o_re     = 1'b1;
                            o_raddr  = r_head;
                            n_rel    = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_TICK_CMP;
                        end
                    end
                end
            end

            S_INS_CMP: begin
                o_we = 1'b1;
                if (i_rdata.wake_time > r_new.wake_time) begin
                    // Later entry moves up one slot to open room below it.
                    o_wdata = i_rdata;
                    n_wr    = r_ptr;
                    if (r_left == CW'(1)) begin
                        n_state = S_INS_WR;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = f_dec(r_ptr);
                        n_ptr   = f_dec(r_ptr);
                        n_left  = r_left - 1'b1;
                    end
                end else begin
                    n_tail  = f_inc(r_tail);
                    n_count = r_count + 1'b1;
                    n_state = S_EMIT;
                end
            end

            S_INS_WR: begin
                o_we    = 1'b1;
                n_tail  = f_inc(r_tail);
                n_count = r_count + 1'b1;
                n_state = S_EMIT;
            end

            S_TICK_CMP: begin
                // The held release goes out once the next compare tells whether it is last.
                if (!r_pend_v || i_out_free) begin
                    if (r_pend_v) begin
                        o_res_load = 1'b1;
                        o_res.last = !expired;
                    end
                    if (expired) begin
                        n_pend   = '{status: ST_WOKEN, woken_id: i_rdata.waiter_id,
                                     woken_time: i_rdata.wake_time, last: 1'b1};
                        n_pend_v = 1'b1;
                        n_head   = f_inc(r_head);
                        n_count  = r_count - 1'b1;
                        n_rel    = r_rel + 1'b1;
                        if (r_count == CW'(1) || r_rel == REL_W'(MAX_RESULTS - 1)) begin
                            n_state = S_EMIT;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = f_inc(r_head);
                        end
                    end else if (r_pend_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pend  = '{status: ST_NONE, woken_id: '0, woken_time: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_wr   <= n_wr;
        r_left <= n_left;
        r_rel  <= n_rel;
        r_new  <= n_new;
        r_now  <= n_now;
        r_pend <= n_pend;
    end

endmodule
